### rtl/psl_pkg.sv
package psl_pkg;

   localparam int LIMIT_W = 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_OUTER_RD,
      ST_OUTER_CHK,
      ST_MARK,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_FLUSH
   } psl_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic fill;
      logic i_init;
      logic i_read;
      logic i_next;
      logic j_init;
      logic mark;
      logic scan_init;
      logic scan_read;
      logic take;
      logic v_next;
      logic flush;
   } psl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic fill_done;
      logic n_small;
      logic sq_gt_n;
      logic j_gt_n;
      logic map_bit;
      logic scan_done;
      logic have_pending;
      logic out_free;
   } psl_status_type;

endpackage

### rtl/psl_req_if.sv
interface psl_req_if
   import psl_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [LIMIT_W-1:0] limit;

   modport source (output valid, output limit, input ready);
   modport sink   (input valid, input limit, output ready);
endinterface

### rtl/psl_rsp_if.sv
interface psl_rsp_if
   import psl_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [LIMIT_W-1:0] prime_value;
   logic               last;

   modport source (output valid, output prime_value, output last, input ready);
   modport sink   (input valid, input prime_value, input last, output ready);
endinterface

### rtl/psl_ram.sv
module psl_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/psl_ctrl.sv
module psl_ctrl
   import psl_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  psl_status_type status,
   output psl_cmd_type    cmd
);

   psl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_FILL;
         end
         ST_FILL: begin
            if (status.fill_done) begin
               state_in = status.n_small ? ST_IDLE : ST_OUTER_RD;
            end
         end
         ST_OUTER_RD: begin
            state_in = status.sq_gt_n ? ST_SCAN_RD : ST_OUTER_CHK;
         end
         ST_OUTER_CHK: begin
            state_in = status.map_bit ? ST_MARK : ST_OUTER_RD;
         end
         ST_MARK: begin
            if (status.j_gt_n) state_in = ST_OUTER_RD;
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (!(status.map_bit && status.have_pending && !status.out_free)) begin
               state_in = status.scan_done ? ST_FLUSH : ST_SCAN_RD;
            end
         end
         ST_FLUSH: begin
            if (!status.have_pending || status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_FILL: begin
            cmd.fill   = 1'b1;
            cmd.i_init = status.fill_done && !status.n_small;
         end
         ST_OUTER_RD: begin
            cmd.scan_init = status.sq_gt_n;
            cmd.i_read    = !status.sq_gt_n;
         end
         ST_OUTER_CHK: begin
            cmd.j_init = status.map_bit;
            cmd.i_next = !status.map_bit;
         end
         ST_MARK: begin
            cmd.mark   = !status.j_gt_n;
            cmd.i_next = status.j_gt_n;
         end
         ST_SCAN_RD: begin
            cmd.scan_read = 1'b1;
         end
         ST_SCAN_CHK: begin
            if (!(status.map_bit && status.have_pending && !status.out_free)) begin
               cmd.take   = status.map_bit;
               cmd.v_next = !status.scan_done;
            end
         end
         ST_FLUSH: begin
            cmd.flush = status.have_pending && status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### rtl/psl_dpath.sv
module psl_dpath
   import psl_pkg::*;
#(
   parameter int SAT_LIMIT = 255
) (
   input  logic               clock,
   input  logic               reset,
   input  psl_cmd_type        cmd,
   output psl_status_type     status,
   input  logic [LIMIT_W-1:0] req_limit,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [LIMIT_W-1:0] rsp_prime_value,
   output logic               rsp_last
);

   localparam int MAP_DEPTH = SAT_LIMIT + 1;
   localparam int ADDR_W    = $clog2(MAP_DEPTH);

   logic [ADDR_W-1:0]   n_ff, n_in;
   logic [ADDR_W-1:0]   v_ff, v_in;
   logic [ADDR_W-1:0]   i_ff, i_in;
   logic [ADDR_W:0]     j_ff, j_in;
   logic [ADDR_W-1:0]   pend_ff, pend_in;
   logic                have_pend_ff, have_pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LIMIT_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [2*ADDR_W-1:0] sq;
   logic [ADDR_W-1:0]   sat_n;
   logic                out_free;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic                wr_data;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic                rd_data;

   assign sat_n = (req_limit > LIMIT_W'(SAT_LIMIT)) ? ADDR_W'(SAT_LIMIT)
                                                     : ADDR_W'(req_limit);
   assign sq = {{ADDR_W{1'b0}}, i_ff} * {{ADDR_W{1'b0}}, i_ff};
   assign out_free = !rsp_valid_ff || rsp_ready;

   // bit map port steering
   assign wr_en   = cmd.fill || cmd.mark;
   assign wr_addr = cmd.fill ? v_ff : j_ff[ADDR_W-1:0];
   assign wr_data = cmd.fill && (v_ff >= ADDR_W'(2));
   assign rd_en   = cmd.i_read || cmd.scan_read;
   assign rd_addr = cmd.i_read ? i_ff : v_ff;

   psl_ram #(
      .WIDTH (1),
      .DEPTH (MAP_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      n_in         = n_ff;
      v_in         = v_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      pend_in      = pend_ff;
      have_pend_in = have_pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;

      if (cmd.load) begin
         n_in         = sat_n;
         v_in         = '0;
         have_pend_in = 1'b0;
      end
      if (cmd.fill || cmd.v_next) v_in = v_ff + ADDR_W'(1);
      if (cmd.scan_init)          v_in = ADDR_W'(2);
      if (cmd.i_init)             i_in = ADDR_W'(2);
      if (cmd.i_next)             i_in = i_ff + ADDR_W'(1);
      if (cmd.j_init)             j_in = sq[ADDR_W:0];
      if (cmd.mark)               j_in = j_ff + {1'b0, i_ff};

      // one survivor is held back so the final one can be flagged
      if (cmd.take) begin
         if (have_pend_ff) begin
            rsp_valid_in = 1'b1;
            rsp_value_in = LIMIT_W'(pend_ff);
            rsp_last_in  = 1'b0;
         end
         pend_in      = v_ff;
         have_pend_in = 1'b1;
      end
      if (cmd.flush) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = LIMIT_W'(pend_ff);
         rsp_last_in  = 1'b1;
         have_pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         have_pend_ff <= have_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      v_ff         <= v_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      pend_ff      <= pend_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign status.fill_done    = (v_ff == n_ff);
   assign status.n_small      = (n_ff < ADDR_W'(2));
   assign status.sq_gt_n      = (sq > {{ADDR_W{1'b0}}, n_ff});
   assign status.j_gt_n       = (j_ff > {1'b0, n_ff});
   assign status.map_bit      = rd_data;
   assign status.scan_done    = (v_ff == n_ff);
   assign status.have_pending = have_pend_ff;
   assign status.out_free     = out_free;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_value = rsp_value_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

### rtl/prime_sieve_lister.sv
// Prime lister: each request carries an 8-bit limit n (saturated at MAX_LIMIT)
// and the block answers with every prime from 2 to n in ascending order, one
// response per prime, with last set on the final one; a limit below 2 gives no
// response at all. Requests are handled one at a time: req.ready is high only
// while the block is idle. The work runs on a single-port-write, single-port-
// read bit map of MAX_LIMIT+1 entries (capped at 256): the block takes the
// request, marks the map, steps the outer index from 2 to sqrt(n), clears
// the multiples of each prime it finds, scans the entries from 2 to n and
// then flags the final response; rsp.ready can hold off any response. The
// map port does one access of each kind per cycle. The next request is taken
// while the final response still sits in the output register, so a slow sink
// does not hold up the start of the next sieve.
module prime_sieve_lister
   import psl_pkg::*;
#(
   parameter int MAX_LIMIT = 255
) (
   input logic clock,
   input logic reset,
   psl_req_if.sink   req,
   psl_rsp_if.source rsp
);

   // limit field is 8 bits, so the map never needs more than 256 entries
   localparam int SAT_LIMIT = (MAX_LIMIT < 255) ? MAX_LIMIT : 255;

   psl_cmd_type    cmd;
   psl_status_type status;

   // sequencer: fill, sieve, scan, flush
   psl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // bit map, counters and the output register
   psl_dpath #(
      .SAT_LIMIT (SAT_LIMIT)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_limit       (req.limit),
      .rsp_valid       (rsp.valid),
      .rsp_ready       (rsp.ready),
      .rsp_prime_value (rsp.prime_value),
      .rsp_last        (rsp.last)
   );

endmodule

### rtl/psl_checker.sv
module psl_checker
   import psl_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [LIMIT_W-1:0] rsp_prime_value,
   input logic               rsp_last
);

   logic               in_burst_ff, in_burst_in;
   logic [LIMIT_W-1:0] prev_ff, prev_in;

   // track the last value handed out within one request's list
   always_comb begin
      in_burst_in = in_burst_ff;
      prev_in     = prev_ff;
      if (rsp_valid && rsp_ready) begin
         in_burst_in = !rsp_last;
         prev_in     = rsp_prime_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_burst_ff <= 1'b0;
      end else begin
         in_burst_ff <= in_burst_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_prime_value) && $stable(rsp_last))
      else $error("response changed while stalled");

   a_min_prime: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_prime_value >= LIMIT_W'(2))
      else $error("response below two");

   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && in_burst_ff |-> rsp_prime_value > prev_ff)
      else $error("responses not ascending");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

endmodule

bind prime_sieve_lister psl_checker u_psl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_prime_value (rsp.prime_value),
   .rsp_last        (rsp.last)
);

### bench/prime_sieve_lister_tb.sv
module prime_sieve_lister_tb
   import psl_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // same cap as the block is built with
   localparam int SIEVE_CAP      = 255;
   // long enough for the block to fill up and stall its request side
   localparam int LONG_HOLD      = 3000;
   // beyond the slowest sieve (n = 255) to catch strays
   localparam int DRAIN_CYCLES   = 1200;
   localparam int RANDOM_ITEMS   = 208;
   localparam int QUIET_ITEMS    = 40;

   // ------------------------------------------------------------------
   // expected primes per request, checked in order of arrival
   // ------------------------------------------------------------------
   class prime_scoreboard;
      typedef struct {
         logic [LIMIT_W-1:0] value;
         logic               last;
      } prime_entry_type;

      prime_entry_type expected_primes[$];
      int              failures;

      function void report(string msg);
         failures++;
         if (failures <= 10) begin
            $display("[%0t] mismatch: %s", $time, msg);
         end
      endfunction

      // run the sieve up to the request's limit and queue every survivor
      function void note_request(logic [LIMIT_W-1:0] limit);
         bit              candidate[256];
         int              n;
         int              count;
         prime_entry_type entry;

         n = limit;
         if (n > SIEVE_CAP) begin
            n = SIEVE_CAP;
         end
         for (int v = 0; v <= n; v++) begin
            candidate[v] = 1'b1;
         end
         candidate[0] = 1'b0;
         candidate[1] = 1'b0;
         for (int i = 2; i * i <= n; i++) begin
            if (candidate[i]) begin
               for (int j = i * i; j <= n; j += i) begin
                  candidate[j] = 1'b0;
               end
            end
         end
         count = 0;
         for (int v = 2; v <= n; v++) begin
            if (candidate[v]) begin
               entry.value = v[LIMIT_W-1:0];
               entry.last  = 1'b0;
               expected_primes.push_back(entry);
               count++;
            end
         end
         if (count > 0) begin
            expected_primes[expected_primes.size() - 1].last = 1'b1;
         end
      endfunction

      function void check_response(logic [LIMIT_W-1:0] value, logic last);
         prime_entry_type entry;

         if (expected_primes.size() == 0) begin
            report($sformatf("unexpected response prime_value=%0d last=%0b", value, last));
            return;
         end
         entry = expected_primes.pop_front();
         if (value !== entry.value) begin
            report($sformatf("prime_value expected %0d actual %0d", entry.value, value));
         end
         if (last !== entry.last) begin
            report($sformatf("last expected %0b actual %0b (prime %0d)",
                             entry.last, last, entry.value));
         end
      endfunction

      function int pending();
         return expected_primes.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   psl_req_if req_ch ();
   psl_rsp_if rsp_ch ();

   prime_scoreboard board;

   // stimulus flags shared with the response side
   bit rsp_long_hold;
   bit quiet;

   prime_sieve_lister #(
      .MAX_LIMIT(SIEVE_CAP)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   initial begin
      clock = 1'b0;
   end

   always #1 clock = ~clock;

   // hard stop in case the block hangs
   initial begin
      #3_000_000;
      $display("Some tests failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------

   // offer one limit and hold it until the block takes the request; an
   // optional idle burst goes in front so gaps land on every sieve phase
   task automatic send_limit(input logic [LIMIT_W-1:0] value);
      int gap;

      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_ch.valid <= 1'b0;
         req_ch.limit <= LIMIT_W'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.limit <= value;
      do begin
         @(posedge clock);
      end while (!req_ch.ready);
      // accepted at this edge
      board.note_request(value);
   endtask

   // ------------------------------------------------------------------
   // response side: check every accepted response
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         board.check_response(rsp_ch.prime_value, rsp_ch.last);
      end
   end

   // response ready pattern: random stall bursts, calm stretches, and one
   // long hold-off counted here while the request side keeps offering
   initial begin
      int  hold_left;
      int  stall_left;
      int  cycle_count;
      bit  calm;

      hold_left   = 0;
      stall_left  = 0;
      cycle_count = 0;
      calm        = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         cycle_count++;
         // at the start of each new stretch pick whether it idles at all
         if (cycle_count % 64 == 0) begin
            calm = ($urandom_range(0, 2) == 0);
         end
         if (rsp_long_hold) begin
            rsp_long_hold = 1'b0;
            hold_left     = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
               stall_left = $urandom_range(1, 7);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      logic [LIMIT_W-1:0] directed[];
      logic [LIMIT_W-1:0] limit;

      // edges of the range, primes, prime squares and limits below two
      directed = '{
         8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd255, 8'd254, 8'd128, 8'd127,
         8'd97, 8'd25, 8'd49, 8'd121, 8'd169, 8'd8, 8'd9, 8'd16, 8'd30,
         8'd1, 8'd2, 8'd0, 8'd251, 8'd170
      };
      board         = new();
      rsp_long_hold = 1'b0;
      quiet         = 1'b0;
      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.limit  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[k]) begin
         send_limit(directed[k]);
      end

      // the response side stalls for a long stretch while requests keep coming
      rsp_long_hold = 1'b1;

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == RANDOM_ITEMS - QUIET_ITEMS) begin
            quiet = 1'b1;
         end
         // mostly small limits keep the run short; a few span the full range
         case ($urandom_range(0, 9))
            0:       limit = LIMIT_W'($urandom_range(0, 3));
            1, 2:    limit = LIMIT_W'($urandom_range(0, 255));
            default: limit = LIMIT_W'($urandom_range(0, 63));
         endcase
         send_limit(limit);
      end
      req_ch.valid <= 1'b0;

      // wait for every expected prime, then for any stray response
      while (board.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.pending() != 0) begin
         board.report($sformatf("%0d primes never arrived", board.pending()));
      end
      if (board.failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
